>>> src/tse_pkg.sv
package tse_pkg;

  // Widths of the external fields
  localparam int ACTION_W = 2;
  localparam int VERTEX_W = 5;
  localparam int CFG_W    = 6;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_W-1:0] VCOUNT_RST = 6'd32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEG_RD,
    ST_DEG_ACC,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_DEC,
    ST_SCAN,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic add_edge;
    logic clear_all;
    logic run_init;
    logic deg_rd;
    logic deg_acc;
    logic idx_clr;
    logic seed_step;
    logic pop;
    logic emit_vertex;
    logic dec;
    logic scan_start;
    logic scan_step;
    logic emit_status;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic idx_zero;
    logic top_zero;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/tse_ctrl.sv
module tse_ctrl import tse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [ACTION_W-1:0] action_i,
  input  dp_status_t          status_i,
  output logic                in_ready_o,
  output dp_cmd_t             cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && action_i == ACT_RUN) state_d = ST_DEG_RD;
      end
      ST_DEG_RD: begin
        state_d = status_i.idx_end ? ST_SEED : ST_DEG_ACC;
      end
      ST_DEG_ACC:  state_d = ST_DEG_RD;
      ST_SEED: begin
        if (status_i.idx_end) state_d = ST_POP;
      end
      ST_POP: begin
        state_d = status_i.top_zero ? ST_STATUS : ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        if (status_i.out_free) state_d = ST_DEC;
      end
      ST_DEC:      state_d = ST_SCAN;
      ST_SCAN: begin
        if (status_i.idx_zero) state_d = ST_POP;
      end
      ST_STATUS: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.add_edge    = in_valid_i && action_i == ACT_ADD;
        cmd_o.clear_all   = in_valid_i && action_i == ACT_CLEAR;
        cmd_o.run_init    = in_valid_i && action_i == ACT_RUN;
      end
      ST_DEG_RD: begin
        cmd_o.deg_rd      = !status_i.idx_end;
        cmd_o.idx_clr     = status_i.idx_end;
      end
      ST_DEG_ACC:  cmd_o.deg_acc     = 1'b1;
      ST_SEED:     cmd_o.seed_step   = !status_i.idx_end;
      ST_POP:      cmd_o.pop         = !status_i.top_zero;
      ST_POP_WAIT: cmd_o.emit_vertex = status_i.out_free;
      ST_DEC: begin
        cmd_o.dec         = 1'b1;
        cmd_o.scan_start  = 1'b1;
      end
      ST_SCAN:     cmd_o.scan_step   = !status_i.idx_zero;
      ST_STATUS:   cmd_o.emit_status = status_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

  // Status goes out only once the ready stack has drained
  a_status_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STATUS |-> status_i.top_zero)
    else $error("status reached with vertices left on the stack");

  a_wait_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP_WAIT |-> ($past(state_q) == ST_POP || $past(state_q) == ST_POP_WAIT))
    else $error("stack read wait entered without a pop");

  a_dec_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DEC |-> $past(state_q) == ST_POP_WAIT)
    else $error("successor update without an emitted vertex");

endmodule

>>> src/tse_datapath.sv
module tse_datapath import tse_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic [VERTEX_W-1:0] src_i,
  input  logic [VERTEX_W-1:0] dst_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [VERTEX_W-1:0] vertex_o,
  output logic                is_status_o,
  output logic                acyclic_o,
  output logic                last_o
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // ---------------- vertex count register ----------------
  logic [CFG_W-1:0] vcount_q;
  logic [CW-1:0]    n_act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RST;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_data_i;
    end
  end

  assign n_act = (int'(vcount_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_q);

  // ---------------- counters ----------------
  logic [CW-1:0] idx_q, idx_m1;
  logic [CW-1:0] top_q, top_m1;
  logic [CW-1:0] emitted_q;
  logic [VW-1:0] stk_rd_q;

  assign idx_m1 = idx_q - CW'(1);
  assign top_m1 = top_q - CW'(1);

  // ---------------- adjacency store ----------------
  // Row valid bits let a clear act at once; stale rows read as zero.
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic [MAX_VERTICES-1:0] adj_rd_q;
  logic                    adj_rd_vld_q;
  logic [MAX_VERTICES-1:0] row;
  logic [MAX_VERTICES-1:0] dst_bit;
  logic [VW-1:0]           src_idx, dst_idx, adj_raddr;
  logic                    add_ok, adj_re;

  assign src_idx  = VW'(src_i);
  assign dst_idx  = VW'(dst_i);
  assign dst_bit  = MAX_VERTICES'(1) << dst_i;
  assign add_ok   = cmd_i.add_edge && (7'(src_i) < 7'(n_act)) && (7'(dst_i) < 7'(n_act));
  assign adj_re   = cmd_i.deg_rd || cmd_i.emit_vertex;
  assign adj_raddr = cmd_i.emit_vertex ? stk_rd_q : idx_q[VW-1:0];
  assign row      = adj_rd_vld_q ? adj_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (add_ok) begin
      if (row_vld_q[src_idx]) begin
        adj_mem[src_idx][dst_idx] <= 1'b1;
      end else begin
        adj_mem[src_idx] <= dst_bit;
      end
    end
    if (adj_re) begin
      adj_rd_q     <= adj_mem[adj_raddr];
      adj_rd_vld_q <= row_vld_q[adj_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (cmd_i.clear_all) begin
      row_vld_q <= '0;
    end else if (add_ok) begin
      row_vld_q[src_idx] <= 1'b1;
    end
  end

  // ---------------- in-degree lanes ----------------
  logic [CW-1:0]           deg_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] zero_vec;
  logic [MAX_VERTICES-1:0] newzero_q;

  for (genvar j = 0; j < MAX_VERTICES; j++) begin : g_lane
    assign zero_vec[j] = (deg_q[j] == '0);

    always_ff @(posedge clk_i) begin
      if (cmd_i.run_init) begin
        deg_q[j] <= '0;
      end else if (cmd_i.deg_acc) begin
        deg_q[j] <= deg_q[j] + CW'(row[j]);
      end else if (cmd_i.dec && row[j] && !zero_vec[j]) begin
        deg_q[j] <= deg_q[j] - CW'(1);
      end
      if (cmd_i.dec) begin
        newzero_q[j] <= row[j] && (deg_q[j] == CW'(1));
      end
    end
  end

  // ---------------- ready stack ----------------
  logic [VW-1:0] stk_mem [MAX_VERTICES];
  logic          push_en;
  logic [VW-1:0] push_val;

  always_comb begin
    push_en  = 1'b0;
    push_val = idx_q[VW-1:0];
    if (cmd_i.seed_step) begin
      push_en  = zero_vec[idx_q[VW-1:0]];
    end else if (cmd_i.scan_step) begin
      push_en  = newzero_q[idx_m1[VW-1:0]];
      push_val = idx_m1[VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) stk_mem[top_q[VW-1:0]] <= push_val;
    if (cmd_i.pop) stk_rd_q <= stk_mem[top_m1[VW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q     <= '0;
      emitted_q <= '0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.run_init) begin
        top_q <= '0;
      end else if (push_en) begin
        top_q <= top_q + CW'(1);
      end else if (cmd_i.pop) begin
        top_q <= top_m1;
      end

      if (cmd_i.run_init) begin
        emitted_q <= '0;
      end else if (cmd_i.emit_vertex) begin
        emitted_q <= emitted_q + CW'(1);
      end

      if (cmd_i.run_init || cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.deg_acc || cmd_i.seed_step) begin
        idx_q <= idx_q + CW'(1);
      end else if (cmd_i.scan_start) begin
        idx_q <= n_act;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_m1;
      end
    end
  end

  // ---------------- output register ----------------
  logic                out_valid_q;
  logic [VERTEX_W-1:0] vertex_q;
  logic                is_status_q, acyclic_q, last_q;
  logic                out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_vertex || cmd_i.emit_status) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_vertex) begin
      vertex_q    <= VERTEX_W'(stk_rd_q);
      is_status_q <= 1'b0;
      acyclic_q   <= 1'b0;
      last_q      <= 1'b0;
    end else if (cmd_i.emit_status) begin
      vertex_q    <= '0;
      is_status_q <= 1'b1;
      acyclic_q   <= (emitted_q >= n_act);
      last_q      <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = vertex_q;
  assign is_status_o = is_status_q;
  assign acyclic_o   = acyclic_q;
  assign last_o      = last_q;

  assign status_o.idx_end  = (idx_q == n_act);
  assign status_o.idx_zero = (idx_q == '0);
  assign status_o.top_zero = (top_q == '0);
  assign status_o.out_free = out_free;

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |-> top_q != CW'(MAX_VERTICES))
    else $error("ready stack overflow");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> top_q != '0)
    else $error("pop from empty ready stack");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (idx_q != '0 && idx_q <= n_act))
    else $error("successor scan index out of range");

endmodule

>>> src/topological_sort_engine.sv
// Channel  Dir  Handshake                   Payload
// in       in   in_valid_i / in_stall_o     action_i, src_i, dst_i
// out      out  out_valid_o / out_stall_i   vertex_o, is_status_o, acyclic_o, last_o
// cfg      in   cfg_valid_i / cfg_ready_o   cfg_data_i (vertex_count)
//
// Add-edge and clear transfers are accepted back to back.
// A run with n vertices in use reads and accumulates each adjacency row for
// in-degrees, seeds the stack with one step per vertex, and per popped vertex
// does a stack read, a row read and an n-step successor scan.
// Reset clears the graph (row valid bits), stack pointer, index and emitted count at once.
// Output stalls hold the sequencer; input is stalled for the whole run.
module topological_sort_engine import tse_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [VERTEX_W-1:0] src_i,
  input  logic [VERTEX_W-1:0] dst_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VERTEX_W-1:0] vertex_o,
  output logic                is_status_o,
  output logic                acyclic_o,
  output logic                last_o,
  // vertex_count register
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // Register writes always complete; the user, not the block, keeps them to idle.
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !in_ready;

  tse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  tse_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .src_i       (src_i),
    .dst_i       (dst_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .vertex_o    (vertex_o),
    .is_status_o (is_status_o),
    .acyclic_o   (acyclic_o),
    .last_o      (last_o)
  );

endmodule

>>> tb/tse_order_checker.sv
`timescale 1ns / 100ps

module tse_order_checker import tse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [VERTEX_W-1:0] src_i,
  input  logic [VERTEX_W-1:0] dst_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [VERTEX_W-1:0] vertex_i,
  input  logic                is_status_i,
  input  logic                acyclic_i,
  input  logic                last_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);

  localparam int NUM_V = 32;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                is_status;
    logic                acyclic;
    logic                last;
  } order_item_t;

  logic [NUM_V-1:0] adj_rows [NUM_V];
  logic [CFG_W-1:0] vcount;
  order_item_t      order_q [$];

  // vertices in use, saturating at the matrix size
  function automatic int used_vertices();
    return (vcount > NUM_V) ? NUM_V : int'(vcount);
  endfunction

  // Kahn's order with a LIFO ready stack, then the status item
  task automatic predict_order();
    int               n;
    int               d;
    int               sp;
    int               emitted;
    int               v;
    logic [5:0]       indeg [NUM_V];
    logic [VERTEX_W-1:0] ready [NUM_V];
    n = used_vertices();
    for (int j = 0; j < n; j++) begin
      d = 0;
      for (int i = 0; i < n; i++) begin
        if (adj_rows[i][j]) d++;
      end
      indeg[j] = d[5:0];
    end
    sp = 0;
    emitted = 0;
    for (int i = 0; i < n; i++) begin
      if (indeg[i] == 0 && sp < NUM_V) begin
        ready[sp] = i[VERTEX_W-1:0];
        sp++;
      end
    end
    while (sp != 0) begin
      sp--;
      v = ready[sp];
      order_q.push_back('{vertex: v[VERTEX_W-1:0], is_status: 1'b0, acyclic: 1'b0,
                          last: 1'b0});
      emitted++;
      for (int j = n - 1; j >= 0; j--) begin
        if (adj_rows[v][j] && indeg[j] != 0) begin
          indeg[j]--;
          if (indeg[j] == 0 && sp < NUM_V) begin
            ready[sp] = j[VERTEX_W-1:0];
            sp++;
          end
        end
      end
    end
    order_q.push_back('{vertex: '0, is_status: 1'b1, acyclic: (emitted >= n),
                        last: 1'b1});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    order_item_t got;
    order_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_V; i++) adj_rows[i] = '0;
      vcount = VCOUNT_RST;
      order_q.delete();
      fail_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {vertex_i, is_status_i, acyclic_i, last_i};
        if (order_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("unexpected result: vertex %0d status %0b acyclic %0b last %0b",
                     got.vertex, got.is_status, got.acyclic, got.last);
        end else begin
          want = order_q.pop_front();
          if (got !== want) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display({"result mismatch: expected vertex %0d status %0b acyclic %0b ",
                        "last %0b, got vertex %0d status %0b acyclic %0b last %0b"},
                       want.vertex, want.is_status, want.acyclic, want.last,
                       got.vertex, got.is_status, got.acyclic, got.last);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (action_i)
          ACT_ADD: begin
            if (src_i < used_vertices() && dst_i < used_vertices())
              adj_rows[src_i][dst_i] = 1'b1;
          end
          ACT_RUN:   predict_order();
          ACT_CLEAR: for (int i = 0; i < NUM_V; i++) adj_rows[i] = '0;
          default: ;
        endcase
      end
      // a count written at this edge applies from the next item on
      if (cfg_valid_i && cfg_ready_i) vcount = cfg_data_i;
      pending_o = order_q.size();
    end
  end

endmodule

>>> tb/tb_topological_sort_engine.sv
`timescale 1ns / 100ps

module tb_topological_sort_engine;
  import tse_pkg::*;

  // Action 3 is not decoded by the block; the item must vanish without a result.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  // Longest stretch with no transfer on any channel. A 32-vertex run waits
  // for its in-degree pass before its first vertex and for a successor scan
  // between vertices; this is many times the slowest legal gap.
  localparam int IDLE_LIMIT = 4000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] action = ACT_ADD;
  logic [VERTEX_W-1:0] src = '0;
  logic [VERTEX_W-1:0] dst = '0;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [VERTEX_W-1:0] vertex;
  logic                is_status;
  logic                acyclic;
  logic                last;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;

  int                  fail_cnt;
  int                  pending;

  // sender burst bookkeeping
  int                  burst_left = 0;
  // receiver stall pattern state
  int                  stall_mode = 0;
  int                  stall_span = 0;
  int                  beat = 0;
  int                  idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  topological_sort_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action),
    .src_i       (src),
    .dst_i       (dst),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .vertex_o    (vertex),
    .is_status_o (is_status),
    .acyclic_o   (acyclic),
    .last_o      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  tse_order_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .action_i    (action),
    .src_i       (src),
    .dst_i       (dst),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .vertex_i    (vertex),
    .is_status_i (is_status),
    .acyclic_i   (acyclic),
    .last_i      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  // Receiver: whenever the random span runs out, pick a new stall style - none
  // at all, coin flips, a fixed duty pattern, or sparse random stalls.
  always @(posedge clk_i) begin
    beat <= beat + 1;
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(20, 80);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= (beat % 7) < 3;
      default: out_stall <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One input transfer. Items go out in bursts; when a burst is used up the
  // valid drops for a random gap. Returns at the edge that took the item.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VERTEX_W-1:0] s,
                           input logic [VERTEX_W-1:0] d);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    action   <= act;
    src      <= s;
    dst      <= d;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    burst_left--;
  endtask

  // vertex_count write; only called with the block idle
  task automatic write_count(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait until every predicted result is in, then give adds and
  // clears (no result of their own) time to retire.
  task automatic settle(input int tail);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int vc;
    int n;
    int hi;
    int a;
    int b;
    int k;
    int r;
    int dag_only;
    logic [ACTION_W-1:0] act;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // Empty graph at the reset count: all 32 vertices, pushed ascending,
    // popped in descending order.
    send_item(ACT_RUN, 5'd0, 5'd0);
    // extremes of the endpoints, a self-loop, an ignored action code
    send_item(ACT_ADD, 5'd0, 5'd31);
    send_item(ACT_ADD, 5'd31, 5'd5);
    send_item(ACT_ADD, 5'd5, 5'd5);
    send_item(ACT_ADD, 5'd3, 5'd4);
    send_item(ACT_UNUSED, 5'd31, 5'd31);
    send_item(ACT_RUN, 5'd31, 5'd31);
    send_item(ACT_CLEAR, 5'd17, 5'd9);
    send_item(ACT_RUN, 5'd0, 5'd0);
    settle(8);

    // no vertices in use: status only, acyclic; adds are out of range
    write_count(6'd0);
    send_item(ACT_RUN, 5'd0, 5'd0);
    send_item(ACT_ADD, 5'd0, 5'd0);
    send_item(ACT_RUN, 5'd0, 5'd0);
    settle(8);

    // count above the matrix size saturates at 32
    write_count(6'd63);
    send_item(ACT_ADD, 5'd31, 5'd0);
    send_item(ACT_ADD, 5'd30, 5'd31);
    send_item(ACT_RUN, 5'd0, 5'd0);
    settle(8);

    // single vertex with a self-loop; add to vertex 1 is out of range
    write_count(6'd1);
    send_item(ACT_ADD, 5'd0, 5'd0);
    send_item(ACT_ADD, 5'd1, 5'd0);
    send_item(ACT_RUN, 5'd0, 5'd0);
    settle(8);

    // lowered count: edges on vertices 30/31 stay stored but are skipped
    write_count(6'd3);
    send_item(ACT_ADD, 5'd1, 5'd2);
    send_item(ACT_RUN, 5'd0, 5'd0);
    settle(8);

    // back to full size - the kept edges count again
    write_count(6'd32);
    send_item(ACT_RUN, 5'd0, 5'd0);
    settle(8);

    // --- random part ---
    // Each phase sets a count (mostly small), then either a clean sequence
    // (clear, a batch of edges, run) or a burst of noise closed by a run.
    sent = 0;
    while (sent < 80) begin
      r = $urandom_range(0, 19);
      if (r == 0)      vc = 0;
      else if (r == 1) vc = $urandom_range(33, 63);
      else if (r == 2) vc = 32;
      else if (r < 5)  vc = $urandom_range(9, 16);
      else             vc = $urandom_range(1, 8);
      write_count(vc[CFG_W-1:0]);
      n  = (vc > 32) ? 32 : vc;
      hi = (n > 0) ? n - 1 : 31;

      if ($urandom_range(0, 4) != 0) begin
        dag_only = ($urandom_range(0, 2) != 0);
        send_item(ACT_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
        sent++;
        k = $urandom_range(0, 2 * n + 1);
        for (int e = 0; e < k; e++) begin
          a = $urandom_range(0, hi);
          b = $urandom_range(0, hi);
          if (dag_only && a > b) begin
            r = a;
            a = b;
            b = r;
          end
          // forward edges only keeps the graph acyclic
          if (!(dag_only && a == b)) begin
            send_item(ACT_ADD, a[VERTEX_W-1:0], b[VERTEX_W-1:0]);
            sent++;
          end
        end
      end else begin
        k = $urandom_range(3, 10);
        for (int e = 0; e < k; e++) begin
          act = ACTION_W'($urandom_range(0, 3));
          send_item(act, VERTEX_W'($urandom), VERTEX_W'($urandom));
          if (act != ACT_UNUSED) sent++;
        end
      end
      send_item(ACT_RUN, VERTEX_W'($urandom), VERTEX_W'($urandom));
      sent++;
      settle(8);
    end

    settle(20);
    if (fail_cnt == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
